// ===== rtl/cvt_pkg.sv =====
// ----------------------------------------------------------------------------
// cvt_pkg: shared constants, tables and helpers for camera_view_transform
// Field widths, register and function codes, the arctangent table for the
// rotation cells, and the 32-bit saturation helper.
// ----------------------------------------------------------------------------
package cvt_pkg;

  // Field widths
  localparam int DATA_W    = 32;
  localparam int FUNC_W    = 2;
  localparam int ZOOM_W    = 16;
  localparam int ANG_W     = 16;
  localparam int VIEW_W    = 16;
  localparam int CFG_IDX_W = 3;

  // Divider: quotient bits per lane, one bit per cell
  localparam int DIV_W = 40;

  // Rotation datapath: vector width (guard bits included) and angle width
  localparam int CW = 41;
  localparam int ZW = 34;

  localparam int CORDIC_STAGES_DEF = 16;
  localparam int CORDIC_MAX        = 24;

  // Inverse gain in Q24
  localparam logic signed [24:0] INV_GAIN = 25'sd10188014;

  // Register reset values and zoom floor
  localparam logic [ZOOM_W-1:0] ZOOM_MIN   = 16'd3;
  localparam logic [ZOOM_W-1:0] ZOOM_RESET = 16'd256;
  localparam logic [VIEW_W-1:0] VIEW_RESET = 16'd1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ZOOM     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_VIEW_W   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_VIEW_H   = 3'd5;

  // Function codes
  localparam logic [FUNC_W-1:0] FUNC_W2S = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_S2W = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_VIS = 2'd2;

  // atan(2^-i) in units of 2^-32 turn
  localparam logic [31:0] ATAN_TURN [CORDIC_MAX] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  // Saturate a signed 64-bit value to 32 bits
  function automatic logic [DATA_W-1:0] sat32(input logic signed [63:0] v);
    logic [DATA_W-1:0] res;
    if (v > 64'sh0000_0000_7FFF_FFFF) begin
      res = 32'h7FFF_FFFF;
    end else if (v < -64'sh0000_0000_8000_0000) begin
      res = 32'h8000_0000;
    end else begin
      res = v[DATA_W-1:0];
    end
    return res;
  endfunction

endpackage

// ===== rtl/cvt_div_cell.sv =====
// ----------------------------------------------------------------------------
// cvt_div_cell: one restoring-division cell
// Shifts one dividend bit into the partial remainder, subtracts the divisor
// when it fits and shifts the quotient bit into the work word.
// ----------------------------------------------------------------------------
module cvt_div_cell (
  input  logic                          clk,
  input  logic                          en,
  input  logic [cvt_pkg::ZOOM_W-1:0]    divisor,
  input  logic [cvt_pkg::ZOOM_W-1:0]    rem_i,
  input  logic [cvt_pkg::DIV_W-1:0]     work_i,
  output logic [cvt_pkg::ZOOM_W-1:0]    rem_o,
  output logic [cvt_pkg::DIV_W-1:0]     work_o
);

  logic [cvt_pkg::ZOOM_W:0]   trial;
  logic                       take;
  logic [cvt_pkg::ZOOM_W-1:0] rem_nxt;
  logic [cvt_pkg::DIV_W-1:0]  work_nxt;
  logic [cvt_pkg::ZOOM_W-1:0] rem_r;
  logic [cvt_pkg::DIV_W-1:0]  work_r;

  // Trial subtract of the divisor
  always_comb begin
    trial    = {rem_i, work_i[cvt_pkg::DIV_W-1]};
    take     = (trial >= {1'b0, divisor});
    rem_nxt  = take ? cvt_pkg::ZOOM_W'(trial - {1'b0, divisor})
                    : trial[cvt_pkg::ZOOM_W-1:0];
    work_nxt = {work_i[cvt_pkg::DIV_W-2:0], take};
  end

  // Advance with the pipeline
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= rem_nxt;
      work_r <= work_nxt;
    end
  end

  assign rem_o  = rem_r;
  assign work_o = work_r;

endmodule

// ===== rtl/cvt_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// cvt_cordic_cell: one rotation-mode CORDIC micro-rotation
// Rotates the vector by +-atan(2^-STAGE) toward a zero residual angle.
// ----------------------------------------------------------------------------
module cvt_cordic_cell #(
  parameter int STAGE = 0
) (
  input  logic                             clk,
  input  logic                             en,
  input  logic signed [cvt_pkg::CW-1:0]    x_i,
  input  logic signed [cvt_pkg::CW-1:0]    y_i,
  input  logic signed [cvt_pkg::ZW-1:0]    z_i,
  output logic signed [cvt_pkg::CW-1:0]    x_o,
  output logic signed [cvt_pkg::CW-1:0]    y_o,
  output logic signed [cvt_pkg::ZW-1:0]    z_o
);

  localparam logic signed [cvt_pkg::ZW-1:0] ATAN =
    {{(cvt_pkg::ZW-32){1'b0}}, cvt_pkg::ATAN_TURN[STAGE]};

  logic signed [cvt_pkg::CW-1:0] dx, dy, x_nxt, y_nxt;
  logic signed [cvt_pkg::ZW-1:0] z_nxt;
  logic signed [cvt_pkg::CW-1:0] x_r, y_r;
  logic signed [cvt_pkg::ZW-1:0] z_r;

  // Pick direction from the sign of the residual angle
  always_comb begin
    dx = y_i >>> STAGE;
    dy = x_i >>> STAGE;
    if (!z_i[cvt_pkg::ZW-1]) begin
      x_nxt = x_i - dx;
      y_nxt = y_i + dy;
      z_nxt = z_i - ATAN;
    end else begin
      x_nxt = x_i + dx;
      y_nxt = y_i - dy;
      z_nxt = z_i + ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  assign x_o = x_r;
  assign y_o = y_r;
  assign z_o = z_r;

endmodule

// ===== rtl/camera_view_transform.sv =====
// ----------------------------------------------------------------------------
// camera_view_transform: 2-D camera world/screen transform
// Pipelined world-to-screen, screen-to-world and visibility test over a
// restoring divider chain and a CORDIC rotation chain.
// ----------------------------------------------------------------------------
//  channel | dir | handshake           | payload
//  in      | in  | in_tvalid/tready    | tuser: func; tdata: in_x, in_y
//  out     | out | out_tvalid/tready   | tuser: visible; tdata: out_x, out_y
//  cfg     | in  | cfg_valid/ready     | cfg_index, cfg_data
//
//  One item per cycle unless stalled; an item passes through the 40-cell
//  divider chain, the CORDIC chain and eight arithmetic stages.
//  Reset clears the pipeline valid bits and loads the register defaults.
//  The pipeline stalls only when its last stage holds a result and the
//  output register is full and not being taken; cfg_ready is always high.
// ----------------------------------------------------------------------------
module camera_view_transform #(
  parameter int CORDIC_STAGES = cvt_pkg::CORDIC_STAGES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // in_tdata: [31:0] in_x, [63:32] in_y; in_tuser: [1:0] func
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [2*cvt_pkg::DATA_W-1:0]    in_tdata,
  input  logic [cvt_pkg::FUNC_W-1:0]      in_tuser,
  // out_tdata: [31:0] out_x, [63:32] out_y; out_tuser: [0] visible
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [2*cvt_pkg::DATA_W-1:0]    out_tdata,
  output logic                            out_tuser,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [cvt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cvt_pkg::DATA_W-1:0]      cfg_data
);

  localparam int DW  = cvt_pkg::DATA_W;
  localparam int QW  = cvt_pkg::DIV_W;
  localparam int NST = QW + 7 + CORDIC_STAGES;
  localparam int VW  = 38;
  localparam int V0W = 37;
  localparam int PW  = cvt_pkg::CW + 25;
  localparam int MW  = 59;
  localparam int NW  = 45;

  typedef struct packed {
    logic [cvt_pkg::FUNC_W-1:0] func;
    logic signed [DW-1:0]       px;
    logic signed [DW-1:0]       py;
    logic signed [DW:0]         ax;
    logic signed [DW:0]         ay;
    logic                       sx;
    logic                       sy;
  } side1_t;

  typedef struct packed {
    logic [cvt_pkg::FUNC_W-1:0] func;
    logic signed [DW-1:0]       px;
    logic signed [DW-1:0]       py;
    logic [VW-1:0]              hw;
    logic [VW-1:0]              hh;
    logic                       rot;
    logic signed [V0W-1:0]      v0x;
    logic signed [V0W-1:0]      v0y;
    logic [cvt_pkg::ANG_W-1:0]  ang;
  } side2_t;

  // Configuration registers
  logic signed [DW-1:0]          cx_r, cy_r;
  logic [cvt_pkg::ZOOM_W-1:0]    zoom_r;
  logic [cvt_pkg::ANG_W-1:0]     angle_r;
  logic [cvt_pkg::VIEW_W-1:0]    vw_r, vh_r;

  assign cfg_ready = 1'b1;

  // Write configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r    <= '0;
      cy_r    <= '0;
      zoom_r  <= cvt_pkg::ZOOM_RESET;
      angle_r <= '0;
      vw_r    <= cvt_pkg::VIEW_RESET;
      vh_r    <= cvt_pkg::VIEW_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        cvt_pkg::REG_CENTER_X: cx_r <= cfg_data;
        cvt_pkg::REG_CENTER_Y: cy_r <= cfg_data;
        cvt_pkg::REG_ZOOM: begin
          zoom_r <= (cfg_data[cvt_pkg::ZOOM_W-1:0] < cvt_pkg::ZOOM_MIN) ?
                    cvt_pkg::ZOOM_MIN : cfg_data[cvt_pkg::ZOOM_W-1:0];
        end
        cvt_pkg::REG_ANGLE:  angle_r <= cfg_data[cvt_pkg::ANG_W-1:0];
        cvt_pkg::REG_VIEW_W: vw_r    <= cfg_data[cvt_pkg::VIEW_W-1:0];
        cvt_pkg::REG_VIEW_H: vh_r    <= cfg_data[cvt_pkg::VIEW_W-1:0];
        default: ;
      endcase
    end
  end

  // Flow control: stall only when the last stage cannot move on
  logic [NST-1:0] vld_r, vld_nxt;
  logic           adv, in_acc;
  logic           out_valid_r, out_valid_nxt;

  assign adv       = !(vld_r[NST-1] && out_valid_r && !out_tready);
  assign in_tready = adv;
  assign in_acc    = in_tvalid && adv;
  assign vld_nxt   = {vld_r[NST-2:0], in_acc};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= vld_nxt;
    end
  end

  // ---------------- input stage: dividends and offsets ----------------
  side1_t                s1_r [QW+1];
  logic [QW-1:0]         p_dvx_r, p_dvy_r;
  side1_t                p_nxt;
  logic [QW-1:0]         dvx_nxt, dvy_nxt;
  logic [DW+1:0]         dfx, dfy, mgx, mgy;

  always_comb begin
    p_nxt.func = in_tuser;
    p_nxt.px   = in_tdata[DW-1:0];
    p_nxt.py   = in_tdata[2*DW-1:DW];
    p_nxt.ax   = {p_nxt.px[DW-1], p_nxt.px} - {cx_r[DW-1], cx_r};
    p_nxt.ay   = {p_nxt.py[DW-1], p_nxt.py} - {cy_r[DW-1], cy_r};
    dfx = {{2{p_nxt.px[DW-1]}}, p_nxt.px} - {3'b0, vw_r, 15'b0};
    dfy = {{2{p_nxt.py[DW-1]}}, p_nxt.py} - {3'b0, vh_r, 15'b0};
    mgx = dfx[DW+1] ? (~dfx + 1'b1) : dfx;
    mgy = dfy[DW+1] ? (~dfy + 1'b1) : dfy;
    if (in_tuser == cvt_pkg::FUNC_VIS) begin
      dvx_nxt  = {1'b0, vw_r, 23'b0};
      dvy_nxt  = {1'b0, vh_r, 23'b0};
      p_nxt.sx = 1'b0;
      p_nxt.sy = 1'b0;
    end else begin
      dvx_nxt  = {mgx[DW-1:0], 8'b0};
      dvy_nxt  = {mgy[DW-1:0], 8'b0};
      p_nxt.sx = dfx[DW+1];
      p_nxt.sy = dfy[DW+1];
    end
  end

  // Load the first stage and advance the side data along the divider
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r[0] <= p_nxt;
      p_dvx_r <= dvx_nxt;
      p_dvy_r <= dvy_nxt;
      for (int k = 0; k < QW; k++) begin
        s1_r[k+1] <= s1_r[k];
      end
    end
  end

  // ---------------- divider chain: |dividend| / zoom ----------------
  logic [cvt_pkg::ZOOM_W-1:0] dx_rem  [QW+1];
  logic [cvt_pkg::ZOOM_W-1:0] dy_rem  [QW+1];
  logic [QW-1:0]              dx_work [QW+1];
  logic [QW-1:0]              dy_work [QW+1];

  assign dx_rem[0]  = '0;
  assign dy_rem[0]  = '0;
  assign dx_work[0] = p_dvx_r;
  assign dy_work[0] = p_dvy_r;

  for (genvar k = 0; k < QW; k++) begin : g_div
    cvt_div_cell u_dx (
      .clk(clk), .en(adv), .divisor(zoom_r),
      .rem_i(dx_rem[k]), .work_i(dx_work[k]),
      .rem_o(dx_rem[k+1]), .work_o(dx_work[k+1])
    );
    cvt_div_cell u_dy (
      .clk(clk), .en(adv), .divisor(zoom_r),
      .rem_i(dy_rem[k]), .work_i(dy_work[k]),
      .rem_o(dy_rem[k+1]), .work_o(dy_work[k+1])
    );
  end

  // ---------------- vector select and quotient clamp ----------------
  localparam logic [QW-1:0] QLIM = QW'(64'h8_0000_0000);

  side2_t                s2_r [CORDIC_STAGES+2];
  side2_t                q1_nxt;
  side1_t                s1e;
  logic [QW-1:0]         qx, qy;
  logic [V0W-1:0]        mx, my;

  always_comb begin
    s1e = s1_r[QW];
    qx  = dx_work[QW];
    qy  = dy_work[QW];
    mx  = (qx > QLIM) ? V0W'(QLIM) : qx[V0W-1:0];
    my  = (qy > QLIM) ? V0W'(QLIM) : qy[V0W-1:0];
    q1_nxt.func = s1e.func;
    q1_nxt.px   = s1e.px;
    q1_nxt.py   = s1e.py;
    q1_nxt.hw   = qx[VW-1:0];
    q1_nxt.hh   = qy[VW-1:0];
    q1_nxt.rot  = (angle_r != '0);
    q1_nxt.ang  = angle_r;
    unique case (s1e.func)
      cvt_pkg::FUNC_W2S: begin
        q1_nxt.v0x = V0W'(s1e.ax);
        q1_nxt.v0y = V0W'(s1e.ay);
        q1_nxt.ang = cvt_pkg::ANG_W'(~angle_r + 1'b1);
      end
      cvt_pkg::FUNC_S2W: begin
        q1_nxt.v0x = s1e.sx ? (~mx + 1'b1) : mx;
        q1_nxt.v0y = s1e.sy ? (~my + 1'b1) : my;
      end
      cvt_pkg::FUNC_VIS: begin
        q1_nxt.v0x = V0W'(65536);
        q1_nxt.v0y = '0;
      end
      default: begin
        q1_nxt.v0x = '0;
        q1_nxt.v0y = '0;
      end
    endcase
  end

  // ---------------- quarter-turn reduction ----------------
  logic signed [cvt_pkg::CW-1:0] cr_x [CORDIC_STAGES+1];
  logic signed [cvt_pkg::CW-1:0] cr_y [CORDIC_STAGES+1];
  logic signed [cvt_pkg::ZW-1:0] cr_z [CORDIC_STAGES+1];
  logic signed [cvt_pkg::CW-1:0] q2_x_r, q2_y_r;
  logic signed [cvt_pkg::ZW-1:0] q2_z_r;
  logic [cvt_pkg::ANG_W-1:0]     asum, ares;
  logic [1:0]                    quad;
  logic signed [V0W-1:0]         xs, ys;
  side2_t                        s20;

  always_comb begin
    s20  = s2_r[0];
    asum = s20.ang + 16'h2000;
    quad = asum[15:14];
    ares = s20.ang - {quad, 14'b0};
    unique case (quad)
      2'd0: begin xs = s20.v0x;            ys = s20.v0y;            end
      2'd1: begin xs = ~s20.v0y + 1'b1;    ys = s20.v0x;            end
      2'd2: begin xs = ~s20.v0x + 1'b1;    ys = ~s20.v0y + 1'b1;    end
      default: begin xs = s20.v0y;         ys = ~s20.v0x + 1'b1;    end
    endcase
  end

  // Load the selected vector and advance the side data along the rotation
  always_ff @(posedge clk) begin
    if (adv) begin
      s2_r[0] <= q1_nxt;
      s2_r[1] <= s20;
      for (int k = 0; k < CORDIC_STAGES; k++) begin
        s2_r[k+2] <= s2_r[k+1];
      end
      q2_x_r  <= {{2{xs[V0W-1]}}, xs, 2'b0};
      q2_y_r  <= {{2{ys[V0W-1]}}, ys, 2'b0};
      q2_z_r  <= {{(cvt_pkg::ZW-32){ares[15]}}, ares, 16'b0};
    end
  end

  assign cr_x[0] = q2_x_r;
  assign cr_y[0] = q2_y_r;
  assign cr_z[0] = q2_z_r;

  // ---------------- CORDIC chain ----------------
  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cordic
    cvt_cordic_cell #(.STAGE(k)) u_cell (
      .clk(clk), .en(adv),
      .x_i(cr_x[k]), .y_i(cr_y[k]), .z_i(cr_z[k]),
      .x_o(cr_x[k+1]), .y_o(cr_y[k+1]), .z_o(cr_z[k+1])
    );
  end

  // ---------------- gain removal ----------------
  logic signed [PW-1:0] g1_px_r, g1_py_r;
  side2_t               g1_side_r, g2_side_r, m_side_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      g1_px_r   <= cr_x[CORDIC_STAGES] * cvt_pkg::INV_GAIN;
      g1_py_r   <= cr_y[CORDIC_STAGES] * cvt_pkg::INV_GAIN;
      g1_side_r <= s2_r[CORDIC_STAGES+1];
    end
  end

  localparam logic signed [PW-1:0] GRND = PW'(64'd1 << 25);

  logic signed [PW-1:0] grx, gry;
  logic signed [VW-1:0] g2_vx_nxt, g2_vy_nxt, g2_vx_r, g2_vy_r;

  // Round, then bypass the rotation when the angle is zero
  always_comb begin
    grx = g1_px_r + GRND;
    gry = g1_py_r + GRND;
    if (g1_side_r.rot) begin
      g2_vx_nxt = grx[VW+25:26];
      g2_vy_nxt = gry[VW+25:26];
    end else begin
      g2_vx_nxt = {g1_side_r.v0x[V0W-1], g1_side_r.v0x};
      g2_vy_nxt = {g1_side_r.v0y[V0W-1], g1_side_r.v0y};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      g2_vx_r   <= g2_vx_nxt;
      g2_vy_r   <= g2_vy_nxt;
      g2_side_r <= g1_side_r;
    end
  end

  // ---------------- multiply: zoom or rotated half extents ----------------
  logic signed [39:0] ma0, ma1, ma2, ma3;
  logic signed [18:0] mb0, mb1, mb2, mb3;
  logic [VW-1:0]      abs_c, abs_s;
  logic signed [MW-1:0] m_p0_r, m_p1_r, m_p2_r, m_p3_r;
  logic signed [VW-1:0] m_vx_r, m_vy_r;

  always_comb begin
    abs_c = g2_vx_r[VW-1] ? (~g2_vx_r + 1'b1) : g2_vx_r;
    abs_s = g2_vy_r[VW-1] ? (~g2_vy_r + 1'b1) : g2_vy_r;
    if (g2_side_r.func == cvt_pkg::FUNC_VIS) begin
      ma0 = {2'b0, g2_side_r.hw};  mb0 = {1'b0, abs_c[17:0]};
      ma1 = {2'b0, g2_side_r.hh};  mb1 = {1'b0, abs_s[17:0]};
      ma2 = {2'b0, g2_side_r.hw};  mb2 = {1'b0, abs_s[17:0]};
      ma3 = {2'b0, g2_side_r.hh};  mb3 = {1'b0, abs_c[17:0]};
    end else begin
      ma0 = {{2{g2_vx_r[VW-1]}}, g2_vx_r};  mb0 = {3'b0, zoom_r};
      ma1 = {{2{g2_vy_r[VW-1]}}, g2_vy_r};  mb1 = {3'b0, zoom_r};
      ma2 = '0;                             mb2 = '0;
      ma3 = '0;                             mb3 = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_p0_r   <= ma0 * mb0;
      m_p1_r   <= ma1 * mb1;
      m_p2_r   <= ma2 * mb2;
      m_p3_r   <= ma3 * mb3;
      m_vx_r   <= g2_vx_r;
      m_vy_r   <= g2_vy_r;
      m_side_r <= g2_side_r;
    end
  end

  // ---------------- final arithmetic ----------------
  localparam logic signed [MW-1:0] R8  = MW'(128);
  localparam logic signed [MW-1:0] R16 = MW'(32768);

  logic signed [MW-1:0] t0, t1, hvx, hvy, w0, w1, e0, e1, e2, e3;
  logic signed [63:0]   wide_x, wide_y;
  logic signed [MW-1:0] nw_w, nh_w;
  logic [DW-1:0]        f_ox_nxt, f_oy_nxt;
  logic signed [NW-1:0] f_nw_nxt, f_nh_nxt;
  logic [DW-1:0]        f_ox_r, f_oy_r;
  logic signed [NW-1:0] f_nw_r, f_nh_r;
  logic signed [DW:0]   f_dx_r, f_dy_r;
  logic [cvt_pkg::FUNC_W-1:0] f_func_r;

  always_comb begin
    t0  = (m_p0_r + R8) >>> 8;
    t1  = (m_p1_r + R8) >>> 8;
    hvx = {{(MW-31){1'b0}}, vw_r, 15'b0};
    hvy = {{(MW-31){1'b0}}, vh_r, 15'b0};
    w0  = t0 + hvx;
    w1  = t1 + hvy;
    e0  = (m_p0_r + R16) >>> 16;
    e1  = (m_p1_r + R16) >>> 16;
    e2  = (m_p2_r + R16) >>> 16;
    e3  = (m_p3_r + R16) >>> 16;
    nw_w = e0 + e1;
    nh_w = e2 + e3;
    if (!m_side_r.rot) begin
      nw_w = {{(MW-VW){1'b0}}, m_side_r.hw};
      nh_w = {{(MW-VW){1'b0}}, m_side_r.hh};
    end
    f_nw_nxt = nw_w[NW-1:0];
    f_nh_nxt = nh_w[NW-1:0];
    wide_x   = '0;
    wide_y   = '0;
    unique case (m_side_r.func)
      cvt_pkg::FUNC_W2S: begin
        wide_x = 64'(w0);
        wide_y = 64'(w1);
      end
      cvt_pkg::FUNC_S2W: begin
        wide_x = 64'(m_vx_r) + 64'(cx_r);
        wide_y = 64'(m_vy_r) + 64'(cy_r);
      end
      default: ;
    endcase
    f_ox_nxt = cvt_pkg::sat32(wide_x);
    f_oy_nxt = cvt_pkg::sat32(wide_y);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f_ox_r   <= f_ox_nxt;
      f_oy_r   <= f_oy_nxt;
      f_nw_r   <= f_nw_nxt;
      f_nh_r   <= f_nh_nxt;
      f_dx_r   <= {m_side_r.px[DW-1], m_side_r.px} - {cx_r[DW-1], cx_r};
      f_dy_r   <= {m_side_r.py[DW-1], m_side_r.py} - {cy_r[DW-1], cy_r};
      f_func_r <= m_side_r.func;
    end
  end

  // ---------------- output register ----------------
  logic [DW-1:0]        out_x_r, out_y_r;
  logic                 out_vis_r, vis_nxt;
  logic signed [NW:0]   dxs, dys, nws, nhs;

  // Inclusive box test around the center
  always_comb begin
    dxs = (NW+1)'(f_dx_r);
    dys = (NW+1)'(f_dy_r);
    nws = {f_nw_r[NW-1], f_nw_r};
    nhs = {f_nh_r[NW-1], f_nh_r};
    vis_nxt = (f_func_r == cvt_pkg::FUNC_VIS) &&
              (dxs >= -nws) && (dxs <= nws) &&
              (dys >= -nhs) && (dys <= nhs);
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (adv && vld_r[NST-1]) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Load a finished result
  always_ff @(posedge clk) begin
    if (adv && vld_r[NST-1]) begin
      out_x_r   <= f_ox_r;
      out_y_r   <= f_oy_r;
      out_vis_r <= vis_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_y_r, out_x_r};
  assign out_tuser  = out_vis_r;

endmodule
